FILE: rtl/sha1s_pkg.sv
package sha1s_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_00_19 = 32'h5a827999;
  localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
  localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
  localparam logic [31:0] K_60_79 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] PAD_LIMIT  = 6'd55;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX   = 3'd4;

  // Work for the back end, as sorted by the front end.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_BYTE_END,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Which block of the message tail is being compressed.
  typedef enum logic [1:0] {
    PH_NONE,
    PH_TWO,
    PH_LAST
  } phase_t;

endpackage

FILE: rtl/sha1s_ifs.sv
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

FILE: rtl/sha1s_front.sv
module sha1s_front import sha1s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sha1s_in_if.sink   msg,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  logic accept;
  logic useful;
  cmd_t cmd_next;

  assign msg.ready = !cmd_valid || cmd_ready;
  assign accept    = msg.valid && msg.ready;

  // Items with neither a byte nor an end mark are dropped here.
  assign useful = msg.has_byte || msg.last;

  always_comb begin
    cmd_next.data = msg.data_byte;
    priority if (msg.has_byte && msg.last) begin
      cmd_next.op = OP_BYTE_END;
    end else if (msg.has_byte) begin
      cmd_next.op = OP_BYTE;
    end else begin
      cmd_next.op = OP_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= useful;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: rtl/sha1s_queue.sv
module sha1s_queue import sha1s_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   level;
  logic                push;
  logic                pop;

  assign push_ready = level != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = level != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/sha1s_core.sv
module sha1s_core import sha1s_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         q_ready,
  sha1s_out_if.source  digest
);

  state_t      state;
  state_t      state_next;
  phase_t      phase;
  phase_t      phase_next;
  logic        end_pending;
  logic        end_pending_next;
  logic [28:0] count;
  logic [28:0] count_next;
  logic [6:0]  round;
  logic [6:0]  round_next;
  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [31:0] chain [5];
  logic [31:0] chain_next [5];
  logic [31:0] work [5];
  logic [31:0] work_next [5];
  logic [31:0] blk [16];
  logic [31:0] blk_next [16];

  logic        pop;
  logic        has_byte;
  logic        is_end;
  logic        block_full;
  logic [28:0] count_inc;
  logic [31:0] bit_len;
  logic [5:0]  tail;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] temp;
  logic [31:0] w_new;
  logic        out_take;

  assign pop        = q_valid && q_ready;
  assign has_byte   = (q_cmd.op == OP_BYTE) || (q_cmd.op == OP_BYTE_END);
  assign is_end     = (q_cmd.op == OP_BYTE_END) || (q_cmd.op == OP_END);
  assign count_inc  = count + 29'd1;
  assign block_full = count_inc[5:0] == 6'd0;
  assign bit_len    = {count, 3'b000};
  assign tail       = count[5:0];
  assign out_take   = digest.valid && digest.ready;

  // Round function and constant by round group.
  always_comb begin
    if (round < 7'd20) begin
      f_val = (work[1] & work[2]) ^ (~work[1] & work[3]);
      k_val = K_00_19;
    end else if (round < 7'd40) begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = K_20_39;
    end else if (round < 7'd60) begin
      f_val = (work[1] & work[2]) ^ (work[1] & work[3]) ^ (work[2] & work[3]);
      k_val = K_40_59;
    end else begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = K_60_79;
    end
  end

  assign temp = {work[0][26:0], work[0][31:27]} + f_val + work[4] + k_val + blk[0];

  // The block is a 16-word window that shifts once per round; the word that
  // enters at the top is the next schedule word.
  logic [31:0] w_mix;
  assign w_mix = blk[13] ^ blk[8] ^ blk[2] ^ blk[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          if (has_byte && block_full) begin
            state_next = ST_ROUND;
          end else if (is_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_LEN:   state_next = ST_ROUND;
      ST_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        unique case (phase)
          PH_TWO:  state_next = ST_LEN;
          PH_LAST: state_next = ST_EMIT;
          default: state_next = end_pending ? ST_PAD : ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_take && (idx == LAST_IDX)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    q_ready            = state == ST_IDLE;
    digest.valid       = state == ST_EMIT;
    digest.digest_word = chain[idx];
    digest.word_index  = idx;
    digest.last_word   = idx == LAST_IDX;
  end

  // Datapath.
  always_comb begin
    phase_next       = phase;
    end_pending_next = end_pending;
    count_next       = count;
    round_next       = round;
    idx_next         = idx;
    chain_next       = chain;
    work_next        = work;
    blk_next         = blk;

    unique case (state)
      ST_IDLE: begin
        round_next = '0;
        if (pop && has_byte) begin
          count_next = count_inc;
          for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
              if (6'(i * 4 + j) == tail) begin
                blk_next[i][8 * (3 - j) +: 8] = q_cmd.data;
              end
            end
          end
          if (block_full) begin
            work_next        = chain;
            end_pending_next = is_end;
          end
        end
      end
      ST_PAD: begin
        // Marker byte at the tail, zeros after it.
        for (int i = 0; i < 16; i++) begin
          for (int j = 0; j < 4; j++) begin
            if (6'(i * 4 + j) == tail) begin
              blk_next[i][8 * (3 - j) +: 8] = PAD_BYTE;
            end else if (6'(i * 4 + j) > tail) begin
              blk_next[i][8 * (3 - j) +: 8] = 8'h00;
            end
          end
        end
        end_pending_next = 1'b0;
        work_next        = chain;
        if (tail > PAD_LIMIT) begin
          phase_next = PH_TWO;
        end else begin
          phase_next   = PH_LAST;
          blk_next[14] = '0;
          blk_next[15] = bit_len;
        end
      end
      ST_LEN: begin
        for (int i = 0; i < 15; i++) begin
          blk_next[i] = '0;
        end
        blk_next[15] = bit_len;
        work_next    = chain;
        phase_next   = PH_LAST;
      end
      ST_ROUND: begin
        work_next[0] = temp;
        work_next[1] = work[0];
        work_next[2] = {work[1][1:0], work[1][31:2]};
        work_next[3] = work[2];
        work_next[4] = work[3];
        for (int i = 0; i < 15; i++) begin
          blk_next[i] = blk[i + 1];
        end
        blk_next[15] = w_new;
        round_next   = (round == LAST_ROUND) ? 7'd0 : round + 7'd1;
      end
      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_next[i] = chain[i] + work[i];
        end
        idx_next = '0;
      end
      ST_EMIT: begin
        if (out_take) begin
          if (idx == LAST_IDX) begin
            chain_next = H_INIT;
            count_next = '0;
            phase_next = PH_NONE;
            idx_next   = '0;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_NONE;
      end_pending <= 1'b0;
      count       <= '0;
      round       <= '0;
      idx         <= '0;
      chain       <= H_INIT;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      end_pending <= end_pending_next;
      count       <= count_next;
      round       <= round_next;
      idx         <= idx_next;
      chain       <= chain_next;
    end
  end

  always_ff @(posedge clk) begin
    work <= work_next;
    blk  <= blk_next;
  end

endmodule

FILE: rtl/sha1_stream_hasher.sv
// Channel  Role    Payload                                   Accepted when
// msg      sink    data_byte[7:0], has_byte, last            valid && ready
// digest   source  digest_word[31:0], word_index[2:0],       valid && ready
//                  last_word
//
// Each message byte is written into the block by the back end; a full block then
// runs its rounds and a chaining step. At the message end the tail is padded,
// one or two tail blocks are compressed, and then the back end sends five
// digest items, one per cycle while digest is ready.
// A four-item queue lets msg keep taking items while the rounds run.
// Reset is synchronous and returns the hash to its initial value.
module sha1_stream_hasher import sha1s_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sha1s_in_if.sink     msg,
  sha1s_out_if.source  digest
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  sha1s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  sha1s_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_cmd   (cmd),
    .push_ready (cmd_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  sha1s_core u_core (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready),
    .digest  (digest)
  );

  // The back end takes no queued work while a digest is going out.
  a_no_pop_while_emit: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> !q_ready)
    else $error("queue popped during digest output");

  // After the final digest word the block is idle again.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=> !digest.valid)
    else $error("digest output continued after the final word");

  // Digest words go out in order with no gap.
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && (digest.word_index == $past(digest.word_index) + 3'd1)))
    else $error("digest word order broken");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int RX_HOLD_LEN = 600;
  localparam int TAIL_CYCLES = 400;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [31:0] RK0 = 32'h5a827999;
  localparam logic [31:0] RK1 = 32'h6ed9eba1;
  localparam logic [31:0] RK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RK3 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1s_in_if  msg_if ();
  sha1s_out_if dig_if ();

  sha1_stream_hasher DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (dig_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  msg_item_t    msg_items [$];
  digest_item_t digest_due [$];
  msg_item_t    next_item;
  digest_item_t got, want;

  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  bit  rx_hold      = 1'b0;
  int  rx_hold_cnt  = 0;
  bit  msg_took     = 1'b0;
  int  fails        = 0;

  // Hash state as the block should hold it.
  logic [31:0] hv [5];
  logic [31:0] blk [16];
  logic [28:0] nbytes;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    hv = SHA1_IV;
    foreach (blk[i]) blk[i] = '0;
    nbytes = '0;
  endfunction

  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] v);
    blk[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = v;
  endfunction

  function automatic void sha1_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wt;
    w = blk;
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3]; e = hv[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = rol(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
        w[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) ^ (~b & d);
        k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (r < 60) begin
        f = (b & c) ^ (b & d) ^ (c & d);
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      t = rol(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d; hv[4] += e;
  endfunction

  // Folds one accepted item into the hash and queues the digest on a message end.
  function automatic void sha1_absorb(input msg_item_t it);
    logic [5:0] r;
    if (it.has_byte) begin
      place_byte(nbytes[5:0], it.data_byte);
      nbytes = nbytes + 1'b1;
      if (nbytes[5:0] == 6'd0) sha1_block();
    end
    if (it.last) begin
      r = nbytes[5:0];
      place_byte(r, PAD_MARK);
      for (int p = r + 1; p < 64; p++) place_byte(p[5:0], 8'h00);
      // No room for the length word: the tail spills into a second block.
      if (r > 6'd55) begin
        sha1_block();
        foreach (blk[i]) blk[i] = '0;
      end
      blk[14] = '0;
      blk[15] = {nbytes, 3'b000};
      sha1_block();
      for (int i = 0; i < 5; i++) begin
        digest_due.push_back('{hv[i], 3'(i), i == 4});
      end
      sha1_restart();
    end
  endfunction

  // Driver: offers queued items and drives the digest side ready.
  always @(negedge clk) begin
    if (rst) begin
      msg_if.valid <= 1'b0;
      dig_if.ready <= 1'b0;
    end else begin
      if (!msg_if.valid || msg_took) begin
        if (msg_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_item = msg_items.pop_front();
          msg_if.valid     <= 1'b1;
          msg_if.data_byte <= next_item.data_byte;
          msg_if.has_byte  <= next_item.has_byte;
          msg_if.last      <= next_item.last;
        end else begin
          msg_if.valid <= 1'b0;
        end
      end
      dig_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: predicts on accepted input items and checks digest items.
  always @(posedge clk) begin
    msg_took = !rst && msg_if.valid && msg_if.ready;
    if (msg_took) begin
      sha1_absorb('{msg_if.data_byte, msg_if.has_byte, msg_if.last});
    end
    if (!rst && dig_if.valid && dig_if.ready) begin
      got = '{dig_if.digest_word, dig_if.word_index, dig_if.last_word};
      if (digest_due.size() == 0) begin
        $error("unexpected digest item: word %h index %0d", got.digest_word, got.word_index);
        fails++;
      end else begin
        want = digest_due.pop_front();
        if (got.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
          fails++;
        end
        if (got.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
          fails++;
        end
        if (got.last_word !== want.last_word) begin
          $error("last_word: expected %b, got %b", want.last_word, got.last_word);
          fails++;
        end
      end
    end
  end

  // Counts out the long receiver hold-off once it has been requested.
  always @(posedge clk) begin
    if (rx_hold) begin
      rx_hold_cnt++;
      if (rx_hold_cnt == RX_HOLD_LEN) begin
        rx_hold = 1'b0;
        rx_hold_cnt = 0;
      end
    end
  end

  task automatic queue_message(input int len, input bit end_only);
    for (int n = 0; n < len; n++) begin
      // Now and then an idle item lands inside the message.
      if ($urandom_range(9) == 0) msg_items.push_back('{8'($urandom), 1'b0, 1'b0});
      msg_items.push_back('{8'($urandom), 1'b1, !end_only && n == len - 1});
    end
    if (end_only || len == 0) msg_items.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  function automatic int pick_len();
    int sel;
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(20);
    if (sel < 80) return edges[$urandom_range(9)];
    return $urandom_range(140, 21);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (msg_items.size() != 0 || msg_if.valid || digest_due.size() != 0);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int goal);
    int sent;
    int len;
    sent = 0;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    while (sent < goal) begin
      len = pick_len();
      queue_message(len, 1'($urandom_range(1)));
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    msg_if.valid     = 1'b0;
    msg_if.data_byte = 8'h00;
    msg_if.has_byte  = 1'b0;
    msg_if.last      = 1'b0;
    dig_if.ready     = 1'b0;
    sha1_restart();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, bytes at both extremes, idle item mid-message,
    // last carried on a byte item and on an end-only item.
    msg_items.push_back('{8'h00, 1'b0, 1'b1});
    msg_items.push_back('{8'h61, 1'b1, 1'b0});
    msg_items.push_back('{8'h62, 1'b1, 1'b0});
    msg_items.push_back('{8'h63, 1'b1, 1'b1});
    msg_items.push_back('{8'h00, 1'b1, 1'b0});
    msg_items.push_back('{8'hff, 1'b0, 1'b0});
    msg_items.push_back('{8'hff, 1'b1, 1'b0});
    msg_items.push_back('{8'h5a, 1'b0, 1'b1});
    msg_items.push_back('{8'hff, 1'b1, 1'b1});
    msg_items.push_back('{8'hff, 1'b0, 1'b1});
    msg_items.push_back('{8'h00, 1'b0, 1'b0});
    msg_items.push_back('{8'h80, 1'b1, 1'b1});
    wait_drained();

    // Tail boundaries: length word fits exactly, spills over, full block.
    queue_message(55, 1'b0);
    queue_message(56, 1'b1);
    queue_message(64, 1'b0);
    run_phase(0, 0, 25);
    run_phase(52, 0, 25);
    run_phase(0, 52, 25);
    run_phase(11, 11, 25);

    // Receiver holds off while short messages keep coming, so the block
    // backs up and stops taking input.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 1'b1;
    for (int m = 0; m < 4; m++) begin
      queue_message($urandom_range(12, 6), 1'($urandom_range(1)));
    end
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $error("timeout: %0d input items and %0d digest items outstanding",
           msg_items.size(), digest_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
